### rtl/core/mibs80_pkg.sv
package mibs80_pkg;

    localparam int BLOCK_W    = 64;
    localparam int HALF_W     = 32;
    localparam int KEY_W      = 80;
    localparam int KEY_HI_W   = 16;
    localparam int RK_W       = 32;
    localparam int RC_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int ROUNDS_DEF = 32;
    localparam int ROUNDS_MAX = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic [3:0] SBOX [16] = '{
        4'h4, 4'hF, 4'h3, 4'h8, 4'hD, 4'hA, 4'hC, 4'h0,
        4'hB, 4'h5, 4'h7, 4'hE, 4'h2, 4'h6, 4'h1, 4'h9
    };

    // One write on the configuration channel.
    typedef struct packed {
        logic                  en;
        logic [CFG_IDX_W-1:0]  idx;
        logic [BLOCK_W-1:0]    data;
    } cfg_wr_t;

    function automatic logic [3:0] sbox4(input logic [3:0] x);
        return SBOX[x];
    endfunction

    // Round function: key addition, S-box layer, nibble mix, nibble permutation.
    function automatic logic [HALF_W-1:0] feistel_f(input logic [HALF_W-1:0] x,
                                                    input logic [RK_W-1:0]   k);
        logic [HALF_W-1:0] s;
        logic [3:0]        n [8];
        logic [3:0]        m [8];
        s = x ^ k;
        for (int i = 0; i < 8; i++)
        begin
            n[i] = sbox4(s[HALF_W-1-4*i -: 4]);
        end
        m[0] = n[1] ^ n[2] ^ n[3] ^ n[4] ^ n[5] ^ n[6];
        m[1] = n[0] ^ n[2] ^ n[3] ^ n[5] ^ n[6] ^ n[7];
        m[2] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[6] ^ n[7];
        m[3] = n[0] ^ n[1] ^ n[2] ^ n[4] ^ n[5] ^ n[7];
        m[4] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[5];
        m[5] = n[0] ^ n[1] ^ n[2] ^ n[5] ^ n[6];
        m[6] = n[1] ^ n[2] ^ n[3] ^ n[6] ^ n[7];
        m[7] = n[0] ^ n[2] ^ n[3] ^ n[4] ^ n[7];
        return {m[2], m[0], m[3], m[6], m[7], m[4], m[5], m[1]};
    endfunction

    // One key schedule step: rotate right by 19, S-box the top byte, add the round number.
    function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k,
                                                  input logic [RC_W-1:0]  rc);
        logic [KEY_W-1:0] t;
        t = {k[18:0], k[KEY_W-1:19]};
        t[79:76] = sbox4(t[79:76]);
        t[75:72] = sbox4(t[75:72]);
        t[18:14] = t[18:14] ^ rc;
        return t;
    endfunction

endpackage

### rtl/core/mibs80_key_sched.sv
module mibs80_key_sched #(
    parameter int ROUNDS = mibs80_pkg::ROUNDS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mibs80_pkg::cfg_wr_t                     cfg_wr,
    output logic [ROUNDS-1:0][mibs80_pkg::RK_W-1:0] round_key,
    output logic                                    keys_ready
);
    import mibs80_pkg::*;

    localparam int CW = $clog2(ROUNDS + 1);

    logic [BLOCK_W-1:0]           key_lo_reg, key_lo_next;
    logic [KEY_HI_W-1:0]          key_hi_reg, key_hi_next;
    logic [KEY_W-1:0]             work_reg, work_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [ROUNDS-1:0][RK_W-1:0]  rk_reg, rk_next;
    logic [KEY_W-1:0]             stepped;
    logic [5:0]                   cnt6;
    logic                         key_write;

    assign cnt6    = 6'(cnt_reg);
    assign stepped = key_step(work_reg, cnt6[RC_W-1:0]);

    always_comb
    begin
        key_lo_next = key_lo_reg;
        key_hi_next = key_hi_reg;
        key_write   = 1'b0;
        if (cfg_wr.en)
        begin
            unique case (cfg_wr.idx)
                REG_KEY_LOW:
                begin
                    key_lo_next = cfg_wr.data;
                    key_write   = 1'b1;
                end
                REG_KEY_HIGH:
                begin
                    key_hi_next = cfg_wr.data[KEY_HI_W-1:0];
                    key_write   = 1'b1;
                end
                default:
                begin
                    key_write = 1'b0;
                end
            endcase
        end
    end

    // The expansion walks one round a cycle; new keys enter at the top and shift down,
    // so after ROUNDS steps entry 0 holds the first round key.
    always_comb
    begin
        work_next = work_reg;
        cnt_next  = cnt_reg;
        rk_next   = rk_reg;
        if (key_write)
        begin
            work_next = {key_hi_next, key_lo_next};
            cnt_next  = CW'(1);
        end
        else if (cnt_reg != '0)
        begin
            work_next = stepped;
            cnt_next  = (cnt_reg == CW'(ROUNDS)) ? '0 : cnt_reg + CW'(1);
            for (int i = 0; i < ROUNDS; i++)
            begin
                rk_next[i] = (i == ROUNDS - 1) ? stepped[KEY_W-1 -: RK_W]
                                               : rk_reg[(i + 1) % ROUNDS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg <= '0;
            key_hi_reg <= '0;
            work_reg   <= '0;
            cnt_reg    <= CW'(1);
        end
        else
        begin
            key_lo_reg <= key_lo_next;
            key_hi_reg <= key_hi_next;
            work_reg   <= work_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rk_reg <= rk_next;
    end

    assign round_key  = rk_reg;
    assign keys_ready = (cnt_reg == '0);

endmodule

### rtl/core/mibs80_round_pipe.sv
module mibs80_round_pipe #(
    parameter int ROUNDS = mibs80_pkg::ROUNDS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [ROUNDS-1:0][mibs80_pkg::RK_W-1:0] round_key,
    input  logic                                    keys_ready,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    in_dec,
    input  logic [mibs80_pkg::BLOCK_W-1:0]          in_block,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mibs80_pkg::BLOCK_W-1:0]          out_block
);
    import mibs80_pkg::*;

    logic [ROUNDS:0]     valid_reg;
    logic [ROUNDS:0]     dec_reg;
    logic [BLOCK_W-1:0]  blk_reg [ROUNDS+1];
    logic [BLOCK_W-1:0]  rnd_out [ROUNDS];
    logic                advance;
    logic                load0;

    // The whole pipe moves together; the entry stage may also fill while it is empty.
    assign advance  = !valid_reg[ROUNDS] || out_ready;
    assign load0    = advance || !valid_reg[0];
    assign in_ready = keys_ready && load0;

    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        logic [HALF_W-1:0] l_half;
        logic [HALF_W-1:0] r_half;
        logic [HALF_W-1:0] f_out;
        logic [RK_W-1:0]   key;

        assign l_half = blk_reg[i][BLOCK_W-1:HALF_W];
        assign r_half = blk_reg[i][HALF_W-1:0];
        // Decryption runs the key list backwards.
        assign key    = dec_reg[i] ? round_key[ROUNDS-1-i] : round_key[i];
        assign f_out  = feistel_f(dec_reg[i] ? r_half : l_half, key);
        assign rnd_out[i] = dec_reg[i] ? {r_half, f_out ^ l_half}
                                       : {f_out ^ r_half, l_half};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load0)
            begin
                valid_reg[0] <= in_valid && in_ready;
            end
            if (advance)
            begin
                valid_reg[ROUNDS:1] <= valid_reg[ROUNDS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            blk_reg[0] <= in_block;
            dec_reg[0] <= in_dec;
        end
        if (advance)
        begin
            for (int i = 0; i < ROUNDS; i++)
            begin
                blk_reg[i+1] <= rnd_out[i];
                dec_reg[i+1] <= dec_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[ROUNDS];
    assign out_block = blk_reg[ROUNDS];

endmodule

### rtl/core/mibs80_block_cipher.sv
// Channel   Direction  Signals                              Contents
// s_axis    in         tvalid tready tuser[0] tdata[63:0]  cmd, block_in
// m_axis    out        tvalid tready tdata[63:0]           block_out
// cfg       in         valid ready index[1:0] data[63:0]   0 key_low, 1 key_high
//
// One item is accepted per cycle while the round keys are ready and m_axis does not
// stall; each item passes one register stage per cipher round plus the entry register.
// After reset and after every write to a key register the key schedule expands
// the round keys one round per cycle, and s_axis_tready stays low until it is done.
// A stall on m_axis freezes all round stages together; the entry stage still takes
// one item while it is empty, so the input never waits on an empty slot.
module mibs80_block_cipher #(
    parameter int ROUNDS = mibs80_pkg::ROUNDS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input items.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [mibs80_pkg::BLOCK_W-1:0]        s_axis_tdata,  // [63:0] block_in
    input  logic                                  s_axis_tuser,  // [0] cmd (1 decrypts)
    // Result items.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [mibs80_pkg::BLOCK_W-1:0]        m_axis_tdata,  // [63:0] block_out
    // Configuration writes.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mibs80_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mibs80_pkg::BLOCK_W-1:0]        cfg_data
);
    import mibs80_pkg::*;

    cfg_wr_t                     cfg_wr;
    logic [ROUNDS-1:0][RK_W-1:0] round_key;
    logic                        keys_ready;

    // Key writes are always taken; a write during expansion simply restarts it.
    assign cfg_ready   = 1'b1;
    assign cfg_wr.en   = cfg_valid && cfg_ready;
    assign cfg_wr.idx  = cfg_index;
    assign cfg_wr.data = cfg_data;

    mibs80_key_sched #(
        .ROUNDS (ROUNDS)
    ) u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .round_key  (round_key),
        .keys_ready (keys_ready)
    );

    // One Feistel round per stage; encryption and decryption share the stages,
    // the direction bit travels with each item and picks the key order.
    mibs80_round_pipe #(
        .ROUNDS (ROUNDS)
    ) u_round_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .round_key  (round_key),
        .keys_ready (keys_ready),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_dec     (s_axis_tuser),
        .in_block   (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_block  (m_axis_tdata)
    );

    // No item may enter while round keys are still being expanded.
    a_no_accept_during_expand: assert property (
        @(posedge clk) disable iff (!rst_n)
        !keys_ready |-> !s_axis_tready
    ) else $error("item accepted while round keys are being expanded");

    // A key write always starts a new expansion.
    a_key_write_expands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH))
        |=> !keys_ready
    ) else $error("key write did not restart the key schedule");

    // While the output is stalled and the entry stage is occupied, no item enters.
    a_stall_blocks_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready && u_round_pipe.valid_reg[0]) |-> !s_axis_tready
    ) else $error("item accepted into an occupied, stalled entry stage");

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mibs80_pkg::*;

    // The testbench predicts every result from its own copy of the key schedule and the
    // round function, then compares each result item against the oldest prediction.
    // Both key registers are kept here and the round keys are rebuilt on every write.

    localparam int NROUND = ROUNDS_DEF;

    // Operation carried on s_axis_tuser.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Register indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // The 4-bit substitution, entry 0 in the top nibble.
    localparam logic [63:0] SUB_NIBBLES = 64'h4F38_DAC0_B57E_2619;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BLOCK_W-1:0]     s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [BLOCK_W-1:0]     m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [BLOCK_W-1:0]     cfg_data      = '0;

    // Predicted key registers and the round keys expanded from them.
    logic [BLOCK_W-1:0]     model_key_low  = '0;
    logic [KEY_HI_W-1:0]    model_key_high = '0;
    logic [RK_W-1:0]        sched_keys [NROUND];

    // Blocks still owed by the cipher, oldest first.
    logic [BLOCK_W-1:0]     expected_blocks [$];

    int mismatch_count = 0;
    int send_idle_pct  = 30;
    int recv_idle_pct  = 56;

    mibs80_block_cipher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [3:0] sub_nibble(input logic [3:0] x);
        return SUB_NIBBLES[63 - 4 * x -: 4];
    endfunction

    // Key addition, substitution of all eight nibbles, the nibble mix and then
    // the nibble permutation. Nibble 0 is the most significant one.
    function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x,
                                                   input logic [RK_W-1:0]   k);
        logic [HALF_W-1:0] s;
        logic [3:0]        n [8];
        logic [3:0]        m [8];
        s = x ^ k;
        for (int i = 0; i < 8; i++)
        begin
            n[i] = sub_nibble(s[HALF_W - 1 - 4 * i -: 4]);
        end
        m[0] = n[1] ^ n[2] ^ n[3] ^ n[4] ^ n[5] ^ n[6];
        m[1] = n[0] ^ n[2] ^ n[3] ^ n[5] ^ n[6] ^ n[7];
        m[2] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[6] ^ n[7];
        m[3] = n[0] ^ n[1] ^ n[2] ^ n[4] ^ n[5] ^ n[7];
        m[4] = n[0] ^ n[1] ^ n[3] ^ n[4] ^ n[5];
        m[5] = n[0] ^ n[1] ^ n[2] ^ n[5] ^ n[6];
        m[6] = n[1] ^ n[2] ^ n[3] ^ n[6] ^ n[7];
        m[7] = n[0] ^ n[2] ^ n[3] ^ n[4] ^ n[7];
        return {m[2], m[0], m[3], m[6], m[7], m[4], m[5], m[1]};
    endfunction

    // Each round rotates the 80-bit key right by 19, substitutes its top byte and
    // folds the round number into bits 18..14. The round key is the top 32 bits.
    function automatic void expand_key_schedule();
        logic [KEY_W-1:0] kreg;
        kreg = {model_key_high, model_key_low};
        for (int r = 1; r <= NROUND; r++)
        begin
            kreg          = {kreg[18:0], kreg[KEY_W-1:19]};
            kreg[79:76]   = sub_nibble(kreg[79:76]);
            kreg[75:72]   = sub_nibble(kreg[75:72]);
            kreg[18:14]   = kreg[18:14] ^ RC_W'(r);
            sched_keys[r - 1] = kreg[79:48];
        end
    endfunction

    // Both directions run on the same round keys; there is no final swap, and
    // decryption walks the keys from the last round back to the first.
    function automatic logic [BLOCK_W-1:0] cipher_model(input logic               dec,
                                                        input logic [BLOCK_W-1:0] blk);
        logic [HALF_W-1:0] lh;
        logic [HALF_W-1:0] rh;
        logic [HALF_W-1:0] t;
        lh = blk[63:32];
        rh = blk[31:0];
        if (dec == CMD_ENCRYPT)
        begin
            for (int i = 0; i < NROUND; i++)
            begin
                t  = round_fn(lh, sched_keys[i]) ^ rh;
                rh = lh;
                lh = t;
            end
        end
        else
        begin
            for (int i = NROUND - 1; i >= 0; i--)
            begin
                t  = round_fn(rh, sched_keys[i]) ^ lh;
                lh = rh;
                rh = t;
            end
        end
        return {lh, rh};
    endfunction

    // ------------------------------------------------------------------
    // Result side: compare every accepted result item and draw the next stall.
    // Outputs are read in the active region of the clock edge, so they still
    // hold the values that the edge itself saw.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        logic [BLOCK_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatch_count++;
                $error("unexpected result item, block_out = %h", m_axis_tdata);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata !== want)
                begin
                    mismatch_count++;
                    $error("block_out: expected %h, actual %h", want, m_axis_tdata);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Shared tasks. Each one is entered and left in the time step of a rising edge.
    // ------------------------------------------------------------------

    // Offers one item after a random gap and records its prediction once it is taken.
    // tvalid stays high on return so that items can follow back to back.
    task automatic send_block(input logic dec, input logic [BLOCK_W-1:0] blk,
                              output logic [BLOCK_W-1:0] predicted);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= dec;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = cipher_model(dec, blk);
        expected_blocks.push_back(predicted);
    endtask

    // Drops tvalid and waits until every predicted result item has come back.
    // The wait loop runs its body before its test, so a following send never touches tvalid
    // twice in the same time step.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_blocks.size() != 0);
    endtask

    // One register write. cfg_valid stays high so writes can follow each other;
    // end_writes lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BLOCK_W-1:0]   value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_KEY_LOW:  model_key_low  = value;
            REG_KEY_HIGH: model_key_high = value[KEY_HI_W-1:0];
            default:      ;
        endcase
        expand_key_schedule();
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // Loads a full master key. Only called with nothing in flight.
    task automatic load_key(input logic [BLOCK_W-1:0] low, input logic [KEY_HI_W-1:0] high);
        write_reg(REG_KEY_LOW, low);
        write_reg(REG_KEY_HIGH, BLOCK_W'(high));
        end_writes();
    endtask

    // A small set of blocks for one key: zero encrypted, all-ones decrypted,
    // a counting pattern, and an encrypt followed by the decrypt of its result.
    task automatic run_block_set();
        logic [BLOCK_W-1:0] ct;
        logic [BLOCK_W-1:0] pt;
        send_block(CMD_ENCRYPT, '0, ct);
        send_block(CMD_DECRYPT, '1, ct);
        send_block(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF, ct);
        pt = {$urandom, $urandom};
        send_block(CMD_ENCRYPT, pt, ct);
        send_block(CMD_DECRYPT, ct, pt);
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Round keys after reset come from an all-zero master key.
    task automatic test_reset_keys();
        logic [BLOCK_W-1:0] ct;
        send_block(CMD_ENCRYPT, '0, ct);
        send_block(CMD_DECRYPT, '0, ct);
        send_block(CMD_ENCRYPT, '1, ct);
        send_block(CMD_DECRYPT, '1, ct);
        wait_for_results();
    endtask

    // Master keys at the corners: all ones, then each register alone at its maximum.
    task automatic test_key_extremes();
        load_key('1, '1);
        run_block_set();
        load_key('1, '0);
        run_block_set();
        load_key('0, '1);
        run_block_set();
    endtask

    // Writes to indexes without a register are dropped, so the key stays as it was.
    task automatic test_ignored_writes();
        logic [BLOCK_W-1:0] ct;
        write_reg(REG_SPARE_2, {$urandom, $urandom});
        write_reg(REG_SPARE_3, {$urandom, $urandom});
        end_writes();
        send_block(CMD_ENCRYPT, {$urandom, $urandom}, ct);
        send_block(CMD_DECRYPT, ct, ct);
        send_block(CMD_DECRYPT, {$urandom, $urandom}, ct);
        wait_for_results();
    endtask

    // Random traffic under one fresh random key and one pair of idle rates. About a
    // quarter of the items turn the previous result back around through the other
    // direction. Somewhere in the middle the sender holds off until the pipeline
    // has emptied completely.
    task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
        logic               dec;
        logic [BLOCK_W-1:0] blk;
        logic [BLOCK_W-1:0] last_out;
        logic               last_dec;
        int                 pause_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        load_key({$urandom, $urandom}, KEY_HI_W'($urandom));
        pause_at = $urandom_range(3 * n_items / 4, n_items / 4);
        last_out = '0;
        last_dec = CMD_ENCRYPT;
        for (int i = 0; i < n_items; i++)
        begin
            if (i == pause_at)
            begin
                wait_for_results();
            end
            if (i > 0 && $urandom_range(3, 0) == 0)
            begin
                dec = ~last_dec;
                blk = last_out;
            end
            else
            begin
                dec = 1'($urandom_range(1, 0));
                blk = {$urandom, $urandom};
            end
            send_block(dec, blk, last_out);
            last_dec = dec;
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        expand_key_schedule();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_keys();
        test_key_extremes();
        test_ignored_writes();

        test_random_traffic(500, 30, 56);
        test_random_traffic(500, 56, 30);
        test_random_traffic(500, 0, 0);

        // Let any stray result item surface before the verdict.
        repeat (NROUND + 8) @(posedge clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // A correct run takes well under a tenth of this.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
rtl/core/mibs80_pkg.sv
rtl/core/mibs80_key_sched.sv
rtl/core/mibs80_round_pipe.sv
rtl/core/mibs80_block_cipher.sv
dv/tb.sv
